// ===== rtl/tef_pkg.sv =====
// types, constants and helpers shared by the edge feature unit
`timescale 1ns / 1ps
package tef_pkg;

    localparam logic OP_NODE = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    localparam int CFG_SCALE_R   = 0;
    localparam int CFG_SCALE_PHI = 1;
    localparam int CFG_SCALE_Z   = 2;
    localparam int CFG_SCALE_ETA = 3;
    localparam int NUM_CFG       = 4;

    // quotient bits of the slope divider and its remainder width
    localparam int QB = 24;
    localparam int RW = 57;

    typedef struct packed {
        logic               operation;
        logic        [9:0]  node_index;
        logic signed [31:0] node_r;
        logic signed [31:0] node_phi;
        logic signed [31:0] node_z;
        logic signed [31:0] node_eta;
        logic        [9:0]  source_index;
        logic        [9:0]  target_index;
    } t_in;

    typedef struct packed {
        logic signed [31:0] delta_r;
        logic signed [31:0] delta_phi;
        logic signed [31:0] delta_z;
        logic signed [31:0] delta_eta;
        logic signed [23:0] phi_slope;
        logic signed [31:0] r_phi_slope;
    } t_out;

    typedef struct packed {
        logic signed [31:0] r;
        logic signed [31:0] phi;
        logic signed [31:0] z;
        logic signed [31:0] eta;
    } t_node;

    typedef struct packed {
        logic signed [31:0] dr;
        logic signed [31:0] dphi;
        logic signed [31:0] dz;
        logic signed [31:0] deta;
        logic signed [32:0] rsum;
    } t_eside;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [31:0]   d;
        logic [QB-1:0] q;
        logic          neg;
        logic          zero;
        logic          ovf;
        t_eside        side;
    } t_dstage;

    typedef struct packed {
        logic       en;
        logic [9:0] idx;
        t_node      data;
    } t_wr;

    typedef struct packed {
        logic       v1;
        logic [9:0] idx1;
        logic       v2;
        logic [9:0] idx2;
    } t_pend;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return $signed(v[31:0]);
        end
    endfunction

endpackage

// ===== rtl/tef_scale.sv =====
// node feature scaling pipeline feeding the node table write port
`timescale 1ns / 1ps
module tef_scale
    import tef_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_in              i_data,
    input  logic [3:0][31:0] i_scale,
    output t_wr              o_wr,
    output t_pend            o_pend
);

    logic              r_v1;
    logic              r_v2;
    logic [9:0]        r_idx1;
    logic [9:0]        r_idx2;
    logic signed [64:0] r_p [4];
    t_node             r_node;

    function automatic logic signed [31:0] f_rnd(input logic signed [64:0] p);
        logic signed [65:0] t;
        t = (66'(p) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return sat32(t);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx1 <= i_data.node_index;
            r_p[0] <= 65'(i_data.node_r)   * 65'($signed({1'b0, i_scale[CFG_SCALE_R]}));
            r_p[1] <= 65'(i_data.node_phi) * 65'($signed({1'b0, i_scale[CFG_SCALE_PHI]}));
            r_p[2] <= 65'(i_data.node_z)   * 65'($signed({1'b0, i_scale[CFG_SCALE_Z]}));
            r_p[3] <= 65'(i_data.node_eta) * 65'($signed({1'b0, i_scale[CFG_SCALE_ETA]}));
            r_idx2     <= r_idx1;
            r_node.r   <= f_rnd(r_p[0]);
            r_node.phi <= f_rnd(r_p[1]);
            r_node.z   <= f_rnd(r_p[2]);
            r_node.eta <= f_rnd(r_p[3]);
        end
    end

    assign o_wr.en   = r_v2;
    assign o_wr.idx  = r_idx2;
    assign o_wr.data = r_node;

    assign o_pend.v1   = r_v1;
    assign o_pend.idx1 = r_idx1;
    assign o_pend.v2   = r_v2;
    assign o_pend.idx2 = r_idx2;

endmodule

// ===== rtl/tef_div.sv =====
// pipelined phi slope divider, one quotient bit per stage, with clamping
`timescale 1ns / 1ps
module tef_div
    import tef_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_eside             i_side,
    output logic               o_valid,
    output logic signed [23:0] o_slope,
    output t_eside             o_side
);

    localparam longint LIM_RAW = longint'(100) <<< FRAC_BITS;
    localparam longint LIM_POS = (LIM_RAW < 64'd8388607) ? LIM_RAW : 64'd8388607;
    localparam longint LIM_NEG = (LIM_RAW < 64'd8388608) ? LIM_RAW : 64'd8388608;

    logic               r_v [QB+2];
    t_dstage            r_st [QB+1];
    logic signed [23:0] r_slope;
    t_eside             r_side;

    logic [32:0]   w_absd;
    logic [32:0]   w_absp;
    logic [RW-1:0] w_num;
    logic [RW-1:0] w_den;
    logic [24:0]   w_mag;
    logic [24:0]   w_lim;
    logic [24:0]   w_cl;

    function automatic t_dstage f_step(input t_dstage s, input int b);
        t_dstage       o;
        logic [RW-1:0] sh;
        o  = s;
        sh = RW'(s.d) << b;
        if (s.rem >= sh) begin
            o.rem  = s.rem - sh;
            o.q[b] = 1'b1;
        end
        return o;
    endfunction

    always_comb begin
        w_absd = i_side.dr[31] ? -33'(i_side.dr) : 33'(i_side.dr);
        w_absp = i_side.dphi[31] ? -33'(i_side.dphi) : 33'(i_side.dphi);
        w_num  = RW'(w_absp) << FRAC_BITS;
        w_den  = RW'(w_absd[31:0]) << QB;
        w_mag  = r_st[QB].ovf ? {25{1'b1}} : {1'b0, r_st[QB].q};
        w_lim  = r_st[QB].neg ? 25'(LIM_NEG) : 25'(LIM_POS);
        w_cl   = (w_mag > w_lim) ? w_lim : w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QB + 2; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < QB + 2; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].rem  <= w_num;
            r_st[0].d    <= w_absd[31:0];
            r_st[0].q    <= '0;
            r_st[0].neg  <= i_side.dr[31] ^ i_side.dphi[31];
            r_st[0].zero <= (i_side.dr == 32'sd0);
            r_st[0].ovf  <= (w_num >= w_den);
            r_st[0].side <= i_side;
            for (int k = 0; k < QB; k++) begin
                r_st[k+1] <= f_step(r_st[k], QB - 1 - k);
            end
            r_side <= r_st[QB].side;
            if (r_st[QB].zero) begin
                r_slope <= '0;
            end else if (r_st[QB].neg) begin
                r_slope <= $signed(24'(-w_cl));
            end else begin
                r_slope <= $signed(w_cl[23:0]);
            end
        end
    end

    assign o_valid = r_v[QB+1];
    assign o_slope = r_slope;
    assign o_side  = r_side;

endmodule

// ===== rtl/track_edge_feature_unit_core.sv =====
// top level of the track edge feature unit: node table, differences and slopes
// usage:
//   input channel (i_valid/o_ready, i_data) takes node writes and edge items,
//   one transfer per cycle while o_ready is high. a node item scales its four
//   features and writes the node table from the scaling registers; it gives
//   no result. an edge item reads source and target entries and gives one
//   result on o_valid/i_ready/o_data after the table read, difference stage,
//   a 26 stage divider (setup, 24 quotient bits one per stage, clamp) and the
//   multiply and rounding stages. throughput is one item per cycle when no
//   hazard or stall holds o_ready low; an edge item that reads an entry still
//   in the node scaling pipeline waits until that write reaches the table.
//   when the receiver stalls, the output register holds and the pipeline
//   advances until a result waits behind it, then halts. reset clears all
//   valid flags and sets the scale registers to 1.0;
//   the node table holds no reset value and must be written before reading.
//   scale registers sit on the apb port at byte addresses 0, 4, 8, 12.
`timescale 1ns / 1ps
module track_edge_feature_unit_core
    import tef_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_NODES);
    localparam logic signed [33:0] ONE34 = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] TWO34 = 34'sd1 <<< (FRAC_BITS + 1);

    logic [3:0][31:0] r_scale;

    t_node r_mem [MAX_NODES];
    t_node r_rd_s;
    t_node r_rd_t;
    logic  r_a_v;
    logic  r_a_soob;
    logic  r_a_toob;

    t_eside r_b;
    logic   r_b_v;

    logic               r_c_v;
    logic signed [56:0] r_c_prod;
    logic signed [23:0] r_c_slope;
    t_eside             r_c_side;

    logic r_out_v;
    t_out r_out;

    logic               w_adv;
    logic               w_out_load;
    logic               w_accept;
    logic               w_hazard;
    t_wr                w_wr;
    t_pend              w_pend;
    logic               w_dv;
    logic signed [23:0] w_slope;
    t_eside             w_dside;
    t_node              w_s;
    t_node              w_t;
    logic signed [33:0] w_dp;
    logic signed [57:0] w_rnd;

    function automatic logic f_in_range(input logic [9:0] idx);
        return 32'(idx) < MAX_NODES;
    endfunction

    // apb configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CFG; k++) begin
                r_scale[k] <= 32'd1 << FRAC_BITS;
            end
        end else if (psel && penable && pwrite) begin
            r_scale[paddr[3:2]] <= pwdata;
        end
    end

    assign prdata = r_scale[paddr[3:2]];
    assign pready = 1'b1;

    // flow control
    assign w_out_load = !r_out_v || i_ready;
    assign w_adv      = w_out_load || !r_c_v;
    assign w_hazard   = (w_pend.v1 && (w_pend.idx1 == i_data.source_index ||
                                       w_pend.idx1 == i_data.target_index)) ||
                        (w_pend.v2 && (w_pend.idx2 == i_data.source_index ||
                                       w_pend.idx2 == i_data.target_index));
    assign o_ready    = w_adv && !(i_data.operation == OP_EDGE && w_hazard);
    assign w_accept   = i_valid && o_ready;

    tef_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_accept && i_data.operation == OP_NODE),
        .i_data  (i_data),
        .i_scale (r_scale),
        .o_wr    (w_wr),
        .o_pend  (w_pend)
    );

    // node table
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_wr.en && f_in_range(w_wr.idx)) begin
                r_mem[AW'(w_wr.idx)] <= w_wr.data;
            end
            r_rd_s   <= r_mem[AW'(i_data.source_index)];
            r_rd_t   <= r_mem[AW'(i_data.target_index)];
            r_a_soob <= !f_in_range(i_data.source_index);
            r_a_toob <= !f_in_range(i_data.target_index);
        end
    end

    // differences
    always_comb begin
        w_s  = r_a_soob ? '0 : r_rd_s;
        w_t  = r_a_toob ? '0 : r_rd_t;
        w_dp = 34'(w_t.phi) - 34'(w_s.phi);
        if (w_dp > ONE34) begin
            w_dp = w_dp - TWO34;
        end else if (w_dp < -ONE34) begin
            w_dp = w_dp + TWO34;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b.dr   <= sat32(66'(34'(w_t.r) - 34'(w_s.r)));
            r_b.dphi <= sat32(66'(w_dp));
            r_b.dz   <= sat32(66'(34'(w_t.z) - 34'(w_s.z)));
            r_b.deta <= sat32(66'(34'(w_t.eta) - 34'(w_s.eta)));
            r_b.rsum <= 33'(w_s.r) + 33'(w_t.r);
        end
    end

    tef_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_b_v),
        .i_side  (r_b),
        .o_valid (w_dv),
        .o_slope (w_slope),
        .o_side  (w_dside)
    );

    // r phi slope product
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_prod  <= 57'(w_dside.rsum) * 57'(w_slope);
            r_c_slope <= w_slope;
            r_c_side  <= w_dside;
        end
    end

    assign w_rnd = (58'(r_c_prod) + (58'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.delta_r     <= r_c_side.dr;
            r_out.delta_phi   <= r_c_side.dphi;
            r_out.delta_z     <= r_c_side.dz;
            r_out.delta_eta   <= r_c_side.deta;
            r_out.phi_slope   <= r_c_slope;
            r_out.r_phi_slope <= sat32(66'(w_rnd));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_adv) begin
                r_a_v <= w_accept && i_data.operation == OP_EDGE;
                r_b_v <= r_a_v;
                r_c_v <= w_dv;
            end
            if (w_out_load) begin
                r_out_v <= r_c_v;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

// ===== rtl/tef_check.sv =====
// port level checker for the edge feature unit and its bind
`timescale 1ns / 1ps
module tef_check
    import tef_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_dr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.delta_r == 32'sd0 |-> o_data.phi_slope == 24'sd0)
        else $error("nonzero slope with zero delta_r");

    a_dphi_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.delta_phi == 32'sd0 |->
        o_data.phi_slope == 24'sd0 && o_data.r_phi_slope == 32'sd0)
        else $error("nonzero slope with zero delta_phi");

endmodule

bind track_edge_feature_unit_core tef_check u_check (.*);
